### hdl/runs_up_down_randomness_test_top_assert.svh
// Assertion macros shared by the runs up and down test modules.
// Every module that uses them has clk_i and rst_ni.
`ifndef RUNS_UP_DOWN_RANDOMNESS_TEST_TOP_ASSERT_SVH
`define RUNS_UP_DOWN_RANDOMNESS_TEST_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define RUDT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define RUDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rudt_pkg.sv
`timescale 1ns / 1ps

package rudt_pkg;

  // Sequence limits
  localparam int unsigned MAX_SAMPLES = 16384;
  localparam int unsigned SAMPLE_BITS = 10;

  // Field widths
  localparam int unsigned CNT_W  = 15;
  localparam int unsigned RUN_W  = 14;
  localparam int unsigned MEAN_W = 14;
  localparam int unsigned VAR_W  = 12;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 64;

  // (2n-1)/3 as a multiply by 21846 and a shift by 16, exact for 15-bit operands
  localparam int unsigned       MEAN_X_W    = 15;
  localparam int unsigned       MEAN_PROD_W = 30;
  localparam int unsigned       MEAN_SHIFT  = 16;
  localparam logic [14:0]       MEAN_RECIP  = 15'd21846;

  // (16n-29)/90 as a multiply by floor(2^24/90), then one correction step
  localparam int unsigned       VAR_V_W     = 18;
  localparam int unsigned       VAR_PROD_W  = 36;
  localparam int unsigned       VAR_SHIFT   = 24;
  localparam logic [17:0]       VAR_RECIP   = 18'd186413;
  localparam logic [17:0]       VAR_DIV     = 18'd90;
  localparam logic [18:0]       VAR_OFFSET  = 19'd29;

  // |z| <= 1.96 as 10000*d^2 <= 38416*var
  localparam int unsigned       SQ_W        = 28;
  localparam int unsigned       LHS_W       = 42;
  localparam logic [13:0]       Z_SCALE     = 14'd10000;
  localparam logic [15:0]       Z_BOUND     = 16'd38416;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MEAN,
    ST_QUOT,
    ST_CORR,
    ST_SQ,
    ST_CMP
  } ctl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;   // a request is accepted this cycle
    logic mean;   // form the two reciprocal products
    logic quot;   // pick the quotient estimates
    logic corr;   // correct the variance, form |runs - mean|
    logic sq;     // square and scale
    logic fin;    // compare, load the summary, clear the sequence
  } dp_cmd_t;

endpackage

### hdl/rudt_ctrl.sv
`timescale 1ns / 1ps
`include "runs_up_down_randomness_test_top_assert.svh"

module rudt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tlast,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output rudt_pkg::dp_cmd_t cmd_o
);

  rudt_pkg::ctl_state_e state_q, state_d;
  logic                 valid_q, valid_d;
  logic                 accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rudt_pkg::ST_RUN;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    accept        = 1'b0;
    valid_d       = valid_q;
    if (valid_q && m_axis_tready) begin
      valid_d = 1'b0;
    end
    case (state_q)
      rudt_pkg::ST_RUN: begin
        s_axis_tready = !valid_q || m_axis_tready;
        accept        = s_axis_tvalid && s_axis_tready;
        cmd_o.take    = accept;
        if (accept) begin
          if (s_axis_tlast) begin
            state_d = rudt_pkg::ST_MEAN;
          end else begin
            valid_d = 1'b1;
          end
        end
      end
      rudt_pkg::ST_MEAN: begin
        cmd_o.mean = 1'b1;
        state_d    = rudt_pkg::ST_QUOT;
      end
      rudt_pkg::ST_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = rudt_pkg::ST_CORR;
      end
      rudt_pkg::ST_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = rudt_pkg::ST_SQ;
      end
      rudt_pkg::ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = rudt_pkg::ST_CMP;
      end
      rudt_pkg::ST_CMP: begin
        cmd_o.fin = 1'b1;
        valid_d   = 1'b1;
        state_d   = rudt_pkg::ST_RUN;
      end
      default: begin
        state_d = rudt_pkg::ST_RUN;
      end
    endcase
  end

  assign m_axis_tvalid = valid_q;

  `RUDT_ASSERT_NEXT(a_last_holds_result, accept && s_axis_tlast, !m_axis_tvalid, "last request shown early")
  `RUDT_ASSERT_NEXT(a_plain_result_next, accept && !s_axis_tlast, m_axis_tvalid, "result not shown after request")
  `RUDT_ASSERT_NEXT(a_summary_shown, cmd_o.fin, m_axis_tvalid && state_q == rudt_pkg::ST_RUN, "summary not shown")

endmodule

### hdl/rudt_dp.sv
`timescale 1ns / 1ps
`include "runs_up_down_randomness_test_top_assert.svh"

module rudt_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rudt_pkg::dp_cmd_t                   cmd_i,
  input  logic [rudt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic [rudt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  // Sequence state
  logic [rudt_pkg::SAMPLE_BITS-1:0] prev_q;
  logic                             have_prev_q;
  rudt_pkg::dir_e                   last_dir_q;
  logic [rudt_pkg::RUN_W-1:0]       runs_q;
  logic [rudt_pkg::CNT_W-1:0]       count_q;
  logic                             ovf_q;

  // Statistics sequence
  logic [rudt_pkg::MEAN_PROD_W-1:0] mean_prod_q;
  logic [rudt_pkg::VAR_V_W-1:0]     var_v_q;
  logic [rudt_pkg::VAR_PROD_W-1:0]  var_prod_q;
  logic [rudt_pkg::MEAN_W-1:0]      mean_q;
  logic [rudt_pkg::VAR_W-1:0]       var_est_q;
  logic [rudt_pkg::VAR_W-1:0]       var_q;
  logic [rudt_pkg::RUN_W-1:0]       diff_q;
  logic [rudt_pkg::SQ_W-1:0]        sq_q;
  logic [rudt_pkg::SQ_W-1:0]        rhs_q;

  // Result register
  logic                             has_dir_q;
  logic                             up_q;
  logic                             done_q;
  logic [rudt_pkg::RUN_W-1:0]       run_out_q;
  logic [rudt_pkg::CNT_W-1:0]       cnt_out_q;
  logic [rudt_pkg::MEAN_W-1:0]      mean_out_q;
  logic [rudt_pkg::VAR_W-1:0]       var_out_q;
  logic                             acc_q;
  logic                             ovf_out_q;

  logic [rudt_pkg::SAMPLE_BITS-1:0] sample;
  logic                             full;
  rudt_pkg::dir_e                   dir_new;
  logic                             has_dir_new;
  logic [rudt_pkg::CNT_W:0]         twice_n;
  logic [rudt_pkg::MEAN_X_W-1:0]    mean_x;
  logic [rudt_pkg::CNT_W+3:0]       sixteen_n;
  logic [rudt_pkg::VAR_V_W-1:0]     var_v;
  logic [rudt_pkg::VAR_V_W-1:0]     var_scaled;
  logic [rudt_pkg::VAR_V_W-1:0]     var_rem;
  logic [rudt_pkg::LHS_W-1:0]       lhs;
  logic                             acc;

  assign sample      = s_axis_tdata[rudt_pkg::SAMPLE_BITS-1:0];
  assign full        = count_q >= rudt_pkg::CNT_W'(rudt_pkg::MAX_SAMPLES);
  assign dir_new     = (sample >= prev_q) ? rudt_pkg::DIR_UP : rudt_pkg::DIR_DOWN;
  assign has_dir_new = !full && have_prev_q;

  // 2n-1 fits 15 bits since n never exceeds the sample limit
  assign twice_n   = {count_q, 1'b0} - {{rudt_pkg::CNT_W{1'b0}}, 1'b1};
  assign mean_x    = twice_n[rudt_pkg::MEAN_X_W-1:0];
  assign sixteen_n = {count_q, 4'b0000};
  assign var_v     = (sixteen_n >= rudt_pkg::VAR_OFFSET)
                   ? rudt_pkg::VAR_V_W'(sixteen_n - rudt_pkg::VAR_OFFSET)
                   : '0;

  assign var_scaled = {{(rudt_pkg::VAR_V_W-rudt_pkg::VAR_W){1'b0}}, var_est_q}
                    * rudt_pkg::VAR_DIV;
  assign var_rem    = var_v_q - var_scaled;

  assign lhs = {{(rudt_pkg::LHS_W-rudt_pkg::SQ_W){1'b0}}, sq_q} * rudt_pkg::Z_SCALE;
  assign acc = (var_q != '0) &&
               (lhs <= {{(rudt_pkg::LHS_W-rudt_pkg::SQ_W){1'b0}}, rhs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      last_dir_q  <= rudt_pkg::DIR_NONE;
      runs_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
    end else if (cmd_i.fin) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      last_dir_q  <= rudt_pkg::DIR_NONE;
      runs_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
    end else if (cmd_i.take) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        if (have_prev_q) begin
          if (dir_new != last_dir_q) begin
            runs_q <= runs_q + 1'b1;
          end
          last_dir_q <= dir_new;
        end
        prev_q      <= sample;
        have_prev_q <= 1'b1;
        count_q     <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean) begin
      mean_prod_q <= {{(rudt_pkg::MEAN_PROD_W-rudt_pkg::MEAN_X_W){1'b0}}, mean_x}
                   * rudt_pkg::MEAN_RECIP;
      var_v_q     <= var_v;
      var_prod_q  <= {{(rudt_pkg::VAR_PROD_W-rudt_pkg::VAR_V_W){1'b0}}, var_v}
                   * rudt_pkg::VAR_RECIP;
    end
    if (cmd_i.quot) begin
      mean_q    <= mean_prod_q[rudt_pkg::MEAN_PROD_W-1:rudt_pkg::MEAN_SHIFT];
      var_est_q <= var_prod_q[rudt_pkg::VAR_SHIFT+rudt_pkg::VAR_W-1:rudt_pkg::VAR_SHIFT];
    end
    if (cmd_i.corr) begin
      var_q  <= var_est_q + rudt_pkg::VAR_W'(var_rem >= rudt_pkg::VAR_DIV);
      diff_q <= (runs_q >= mean_q) ? runs_q - mean_q : mean_q - runs_q;
    end
    if (cmd_i.sq) begin
      sq_q  <= {{(rudt_pkg::SQ_W-rudt_pkg::RUN_W){1'b0}}, diff_q} * diff_q;
      rhs_q <= {{(rudt_pkg::SQ_W-rudt_pkg::VAR_W){1'b0}}, var_q} * rudt_pkg::Z_BOUND;
    end
    if (cmd_i.take) begin
      has_dir_q  <= has_dir_new;
      up_q       <= has_dir_new && (dir_new == rudt_pkg::DIR_UP);
      done_q     <= 1'b0;
      run_out_q  <= '0;
      cnt_out_q  <= '0;
      mean_out_q <= '0;
      var_out_q  <= '0;
      acc_q      <= 1'b0;
      ovf_out_q  <= 1'b0;
    end
    if (cmd_i.fin) begin
      done_q     <= 1'b1;
      run_out_q  <= runs_q;
      cnt_out_q  <= count_q;
      mean_out_q <= mean_q;
      var_out_q  <= var_q;
      acc_q      <= acc;
      ovf_out_q  <= ovf_q;
    end
  end

  assign m_axis_tdata = {6'b0, ovf_out_q, acc_q, var_out_q, mean_out_q,
                         cnt_out_q, run_out_q, up_q};
  assign m_axis_tuser = has_dir_q;
  assign m_axis_tlast = done_q;

  `RUDT_ASSERT_IMPL(a_count_limit, 1'b1, count_q <= rudt_pkg::CNT_W'(rudt_pkg::MAX_SAMPLES), "sample count past limit")
  `RUDT_ASSERT_IMPL(a_runs_bound, 1'b1, runs_q == '0 || rudt_pkg::CNT_W'(runs_q) < count_q, "more runs than comparisons")
  `RUDT_ASSERT_IMPL(a_var_estimate, cmd_i.corr, var_rem < rudt_pkg::VAR_V_W'(2 * rudt_pkg::VAR_DIV), "variance estimate off by more than one")

endmodule

### hdl/runs_up_down_randomness_test_top.sv
`timescale 1ns / 1ps

// Runs up and down randomness test. Stream in one sample per request on the
// slave side (sample in s_axis_tdata[9:0], s_axis_tlast on the final sample of
// a sequence). Every request gives exactly one result on the master side:
// m_axis_tuser says whether the sample was counted and had a predecessor, and
// tdata[0] then says up (greater or equal) or down. On the final sample the
// result also carries the run count, the sample count (saturating at 16384,
// overflow set past that), the truncated mean (2n-1)/3 and variance
// (16n-29)/90, and the accepted flag for |z| <= 1.96; the block then starts a
// fresh sequence. An ordinary result is registered, shown in the cycle after
// its request. A final sample runs the statistics through five steps of the
// controller (two reciprocal multiplies, quotient pick, variance correction,
// squaring, scaled compare) before the summary is shown. The single output
// register lets a new request in on the cycle its result is taken.

module runs_up_down_randomness_test_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample [9:0], zeros above
  input  logic [rudt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tlast,   // last_sample
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // direction_up [0], run_count [14:1], sample_count [29:15],
  // expected_mean [43:30], expected_variance [55:44], accepted [56],
  // overflow [57], zeros above
  output logic [rudt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,   // has_direction
  output logic                                m_axis_tlast,   // done_res
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);

  rudt_pkg::dp_cmd_t cmd;

  // Sequence the handshakes and the statistics steps
  rudt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  // Hold the sequence state, the arithmetic and the result register
  rudt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
